// ----- design/itoa_pkg.sv -----
// itoa_pkg: types, constants and helpers shared by the decimal ascii printer.
// No dependencies; every design file imports this package.

package itoa_pkg;

   // width of the printed integer
   localparam int VALUE_BITS = 16;

   // number of decimal digits of the largest unsigned value at a given width
   function automatic int decimal_digits(input int bits);
      longint m;
      int     n;
      m = (longint'(1) << bits) - 1;
      n = 0;
      while (m > 0) begin
         m = m / 10;
         n = n + 1;
      end
      return n;
   endfunction

   localparam int DIGIT_COUNT  = decimal_digits(VALUE_BITS);
   localparam int CNT_BITS     = $clog2(DIGIT_COUNT + 1);
   localparam int DIG_IDX_BITS = $clog2(DIGIT_COUNT);

   // divide by ten as multiply by reciprocal and shift
   localparam int               RECIP_SHIFT = VALUE_BITS + 3;
   localparam logic [63:0]      RECIP_WIDE  = ((64'd1 << RECIP_SHIFT) / 64'd10) + 64'd1;
   localparam logic [VALUE_BITS:0] RECIP    = RECIP_WIDE[VALUE_BITS:0];
   localparam logic [VALUE_BITS-1:0] TEN    = VALUE_BITS'(10);

   // front to back queue depth
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // characters
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // print mode
   localparam logic FUNC_UNSIGNED = 1'b0;
   localparam logic FUNC_SIGNED   = 1'b1;

   typedef struct packed {
      logic [15:0] value;
      logic        func;
   } req_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last;
   } rsp_type;

   // classified item: sign flag and unsigned magnitude
   typedef struct packed {
      logic                  neg;
      logic [VALUE_BITS-1:0] mag;
   } job_type;

   // digit string, least significant digit in entry 0
   typedef struct packed {
      logic                                neg;
      logic [CNT_BITS-1:0]                 ndig;
      logic [DIGIT_COUNT-1:0][3:0]         digits;
   } digits_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_DIV,
      CONV_HAND
   } conv_state_type;

endpackage

// ----- design/integer_to_decimal_ascii.sv -----
// Decimal ASCII printer: each pushed value (unsigned, or signed two's complement when
// func is set) comes out as its decimal text, one character per beat, a '-' first for a
// negative signed value, most significant digit first, no leading zeros, last set on the
// final character. The divider yields one digit per divide cycle from a
// multiply-by-reciprocal step and then hands the digits off; the output serializer
// loads them and gives one character per beat, the leading '-' first when negative. The
// two overlap through the handoff, so the divider can start on the next value while the
// serializer still sends characters. A two-entry queue and an input stage keep pushes
// flowing while the back end works. Depends on itoa_pkg and the itoa_front, itoa_queue,
// itoa_conv and itoa_emit modules.

module integer_to_decimal_ascii import itoa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic       job_valid, job_ready;
   job_type    job_data;
   logic       q_full_n;
   logic       q_empty, q_pop;
   job_type    q_data;
   logic       hand_valid, hand_ready;
   digits_type hand_data;

   // front: accept and classify
   itoa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data)
   );

   // decoupling queue
   itoa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (job_valid),
      .wr_full  (q_full_n),
      .wr_data  (job_data),
      .rd_en    (q_pop),
      .rd_empty (q_empty),
      .rd_data  (q_data)
   );

   assign job_ready = !q_full_n;

   // back: digit extraction
   itoa_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_data     (q_data),
      .hand_valid (hand_valid),
      .hand_ready (hand_ready),
      .hand_data  (hand_data)
   );

   // back: character serializer
   itoa_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .hand_valid (hand_valid),
      .hand_ready (hand_ready),
      .hand_data  (hand_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   // nothing waits at the output right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result waiting right after reset");

   // every character is a minus sign or a decimal digit
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.text_char == CHAR_MINUS ||
                  (rsp_data.text_char >= CHAR_ZERO && rsp_data.text_char <= CHAR_NINE)))
      else $error("character outside minus and digits");

   // a minus sign never ends a run
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last) |-> (rsp_data.text_char != CHAR_MINUS))
      else $error("run ends on a minus sign");
`endif

endmodule

// ----- design/itoa_front.sv -----
// itoa_front: accepts input beats, masks the value and splits off sign and magnitude.
// Depends on itoa_pkg.

module itoa_front import itoa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);

   logic                  valid_ff, valid_in;
   job_type               job_ff, job_in;
   logic [VALUE_BITS-1:0] value_bits;
   logic                  negative;
   logic                  accept;

   // classify the incoming value
   always_comb begin
      value_bits = VALUE_BITS'(req_data.value);
      negative   = (req_data.func == FUNC_SIGNED) && value_bits[VALUE_BITS-1];
      job_in.neg = negative;
      job_in.mag = negative ? (~value_bits + VALUE_BITS'(1)) : value_bits;
   end

   // one holding stage ahead of the queue
   assign full     = valid_ff && !job_ready;
   assign accept   = push && !full;
   assign valid_in = accept || (valid_ff && !job_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job_data  = job_ff;

endmodule

// ----- design/itoa_queue.sv -----
// itoa_queue: short register queue between the front and the divider.
// Depends on itoa_pkg.

module itoa_queue import itoa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   output logic    wr_full,
   input  job_type wr_data,
   input  logic    rd_en,
   output logic    rd_empty,
   output job_type rd_data
);

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_wr, do_rd;

   assign wr_full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign rd_empty = (count_ff == '0);
   assign do_wr    = wr_en && !wr_full;
   assign do_rd    = rd_en && !rd_empty;
   assign rd_data  = entries_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- design/itoa_conv.sv -----
// itoa_conv: peels decimal digits off the magnitude, one per cycle, least significant first.
// Depends on itoa_pkg.

module itoa_conv import itoa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   output logic       q_pop,
   input  job_type    q_data,
   output logic       hand_valid,
   input  logic       hand_ready,
   output digits_type hand_data
);

   conv_state_type              state_ff, state_in;
   logic [VALUE_BITS-1:0]       mag_ff, mag_in;
   logic                        neg_ff;
   logic [CNT_BITS-1:0]         ndig_ff, ndig_in;
   logic [DIGIT_COUNT-1:0][3:0] digits_ff;
   logic [2*VALUE_BITS:0]       prod;
   logic [VALUE_BITS-1:0]       quot_est, quot;
   logic [VALUE_BITS-1:0]       ten_q;
   logic [VALUE_BITS-1:0]       rem_est, rem;

   // divide by ten: reciprocal multiply, then one correction step
   always_comb begin
      prod     = (2*VALUE_BITS+1)'(mag_ff) * (2*VALUE_BITS+1)'(RECIP);
      quot_est = VALUE_BITS'(prod >> RECIP_SHIFT);
      ten_q    = VALUE_BITS'({quot_est, 3'b000}) + VALUE_BITS'({quot_est, 1'b0});
      rem_est  = mag_ff - ten_q;
      if (rem_est >= TEN) begin
         quot = quot_est + VALUE_BITS'(1);
         rem  = rem_est - TEN;
      end else begin
         quot = quot_est;
         rem  = rem_est;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CONV_IDLE: begin
            if (!q_empty) begin
               state_in = CONV_DIV;
            end
         end
         CONV_DIV: begin
            if (quot == '0) begin
               state_in = CONV_HAND;
            end
         end
         CONV_HAND: begin
            if (hand_ready) begin
               state_in = q_empty ? CONV_IDLE : CONV_DIV;
            end
         end
         default: begin
            state_in = CONV_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      q_pop      = 1'b0;
      hand_valid = 1'b0;
      case (state_ff)
         CONV_IDLE: begin
            q_pop = !q_empty;
         end
         CONV_DIV: begin
            q_pop = 1'b0;
         end
         CONV_HAND: begin
            hand_valid = 1'b1;
            q_pop      = hand_ready && !q_empty;
         end
         default: begin
            q_pop      = 1'b0;
            hand_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath: load on pop, shift one digit out per divide cycle
   assign mag_in  = q_pop ? q_data.mag : quot;
   assign ndig_in = q_pop ? '0 : ndig_ff + CNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         neg_ff  <= q_data.neg;
         mag_ff  <= mag_in;
         ndig_ff <= ndig_in;
      end else if (state_ff == CONV_DIV) begin
         mag_ff  <= mag_in;
         ndig_ff <= ndig_in;
         digits_ff[ndig_ff[DIG_IDX_BITS-1:0]] <= rem[3:0];
      end
   end

   assign hand_data.neg    = neg_ff;
   assign hand_data.ndig   = ndig_ff;
   assign hand_data.digits = digits_ff;

endmodule

// ----- design/itoa_emit.sv -----
// itoa_emit: serializes sign and digits, most significant first, into the output register.
// Depends on itoa_pkg.

module itoa_emit import itoa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       hand_valid,
   output logic       hand_ready,
   input  digits_type hand_data,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data
);

   logic                        busy_ff, busy_in;
   logic                        minus_ff, minus_in;
   logic [CNT_BITS-1:0]         rem_ff, rem_in;
   logic [DIGIT_COUNT-1:0][3:0] digits_ff;
   logic                        out_valid_ff, out_valid_in;
   rsp_type                     out_ff, out_in;
   logic                        load, advance;
   logic [DIG_IDX_BITS-1:0]     idx;

   assign hand_ready = !busy_ff;
   assign load       = hand_valid && !busy_ff;
   assign advance    = busy_ff && (!out_valid_ff || pop);
   assign idx        = DIG_IDX_BITS'(rem_ff - CNT_BITS'(1));

   // next character and sequencing
   always_comb begin
      busy_in      = busy_ff;
      minus_in     = minus_ff;
      rem_in       = rem_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      if (load) begin
         busy_in  = 1'b1;
         minus_in = hand_data.neg;
         rem_in   = hand_data.ndig;
      end else if (advance) begin
         out_valid_in = 1'b1;
         if (minus_ff) begin
            out_in.text_char = CHAR_MINUS;
            out_in.last      = 1'b0;
            minus_in         = 1'b0;
         end else begin
            out_in.text_char = CHAR_ZERO + {4'b0000, digits_ff[idx]};
            out_in.last      = (rem_ff == CNT_BITS'(1));
            rem_in           = rem_ff - CNT_BITS'(1);
            busy_in          = (rem_ff != CNT_BITS'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      minus_ff <= minus_in;
      rem_ff   <= rem_in;
      out_ff   <= out_in;
      if (load) begin
         digits_ff <= hand_data.digits;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule
